// ===== sv/mpbm_pkg.sv =====
// types, codes and helpers shared by the multi-pattern byte matcher
package mpbm_pkg;

  localparam int MAX_RESULTS = 32;
  localparam int ALPHABET    = 256;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET  = 8'd32;

  typedef enum logic [1:0] {
    ACT_INSERT   = 2'd0,
    ACT_FINALIZE = 2'd1,
    ACT_SCAN     = 2'd2,
    ACT_RESTART  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_MATCH  = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_FINAL  = 2'd2
  } kind_t;

  localparam logic [1:0] ST_ADDED   = 2'd0;
  localparam logic [1:0] ST_DUP     = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_TOOLONG = 2'd3;
  localparam logic [1:0] ST_NONE    = 2'd0;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  byte_in;
    logic [15:0] key_value;
    logic        last;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] match_value;
    logic [1:0]  status;
    logic        final_report;
  } out_t;

  typedef struct packed {
    logic        flag;
    logic [15:0] key;
  } info_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_I_CHK,
    S_I_END,
    S_I_FLAG,
    S_I_ERR,
    S_F_RRD,
    S_F_RCHK,
    S_F_DEQ,
    S_F_QW,
    S_F_FN,
    S_F_CRD,
    S_F_CCHK,
    S_F_SRD,
    S_F_SCHK,
    S_F_SFW,
    S_F_DONE,
    S_S_CRD,
    S_S_CCHK,
    S_S_FW,
    S_S_MRD,
    S_S_MCHK,
    S_S_END
  } state_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
    logic [7:0] r;
    r = c;
    if (en && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

// ===== sv/mpbm_ram.sv =====
// generic simple dual-port ram with registered read
module mpbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/multi_pattern_byte_matcher.sv =====
// top level of the multi-pattern byte matcher (trie with failure links)
//
// in channel (in_valid/in_stall/in_data) takes one transaction per action:
// insert a keyword byte, finalize failure links, scan a text byte, or
// restart the scan at the root. out channel (out_valid/out_stall/out_data)
// returns results: one status per keyword end, one done per finalize, and
// zero to 32 match reports per scan byte, the last one flagged final.
// cfg_we/cfg_wdata set the case fold bit; the user must set it only while
// the block is idle, the block does not enforce it. One transaction is
// worked on at a time; in_stall is high while busy. insert: a child
// lookup, then a flag check with a last byte. scan: a child lookup plus a
// failure hop per miss, then each node of the match chain. finalize: every
// byte value of the root, then per queued node its fail link, every byte
// value, each child and its failure hops. All steps are paced by the one
// read port of the child memory and the fail link memory. After reset a
// clearing pass zeroes every child entry, one per cycle, with in_stall
// high. A result waits in the output register while out_stall is high;
// the block holds its work on that result and resumes when it is taken.
module multi_pattern_byte_matcher #(
  parameter int MAX_NODES   = 256,
  parameter int MAX_KEY_LEN = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  mpbm_pkg::in_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output mpbm_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic          cfg_wdata
);

  localparam int NB  = $clog2(MAX_NODES);
  localparam int CAW = NB + 8;
  localparam int DW  = $clog2(MAX_KEY_LEN + 1);
  localparam int KW  = $clog2(mpbm_pkg::MAX_RESULTS + 1);
  localparam int IW  = $bits(mpbm_pkg::info_t);

  localparam logic [NB:0]  NODE_LIMIT = (NB + 1)'(MAX_NODES);
  localparam logic [DW-1:0] KEY_LIMIT = DW'(MAX_KEY_LEN);
  localparam logic [KW-1:0] RES_LIMIT = KW'(mpbm_pkg::MAX_RESULTS);
  localparam logic [NB-1:0] ROOT      = '0;

  mpbm_pkg::state_t state_r, state_nxt;

  logic            case_fold_r;
  logic [CAW-1:0]  clr_r, clr_nxt;
  logic [NB:0]     node_count_r, node_count_nxt;
  logic [NB-1:0]   ins_node_r, ins_node_nxt;
  logic [DW-1:0]   ins_depth_r, ins_depth_nxt;
  logic [1:0]      ins_err_r, ins_err_nxt;
  logic [NB-1:0]   scan_node_r, scan_node_nxt;
  logic [7:0]      c_r, c_nxt;
  logic [15:0]     key_r, key_nxt;
  logic            last_r, last_nxt;
  logic [NB-1:0]   n_r, n_nxt;
  logic [NB-1:0]   s_r, s_nxt;
  logic [NB-1:0]   ch_r, ch_nxt;
  logic [NB-1:0]   fn_r, fn_nxt;
  logic [NB-1:0]   head_r, head_nxt;
  logic [NB-1:0]   tail_r, tail_nxt;
  logic [KW-1:0]   k_r, k_nxt;
  logic            pend_v_r, pend_v_nxt;
  logic [15:0]     pend_r, pend_nxt;
  logic            out_valid_r, out_valid_nxt;
  mpbm_pkg::out_t  out_r, out_nxt;

  // memory ports
  logic            c_we, c_re;
  logic [CAW-1:0]  c_waddr, c_raddr;
  logic [NB-1:0]   c_wdata, c_rdata;
  logic            f_we, f_re;
  logic [NB-1:0]   f_waddr, f_raddr, f_wdata, f_rdata;
  logic            i_we, i_re;
  logic [NB-1:0]   i_waddr, i_raddr;
  mpbm_pkg::info_t i_wdata, i_rdata;
  logic [IW-1:0]   i_rdata_raw;
  logic            q_we, q_re;
  logic [NB-1:0]   q_waddr, q_raddr, q_wdata, q_rdata;

  logic            in_fire;
  logic            slot_free;
  logic            emit;
  mpbm_pkg::out_t  emit_data;
  logic [7:0]      cin;
  logic            child_zero;

  assign in_stall   = (state_r != mpbm_pkg::S_IDLE);
  assign in_fire    = in_valid && !in_stall;
  assign slot_free  = !out_valid_r || !out_stall;
  assign cin        = mpbm_pkg::fold_byte(in_data.byte_in, case_fold_r);
  assign child_zero = (c_rdata == '0);
  assign i_rdata    = mpbm_pkg::info_t'(i_rdata_raw);
  assign out_valid  = out_valid_r;
  assign out_data   = out_r;

  mpbm_ram #(.WIDTH(NB), .DEPTH(MAX_NODES * mpbm_pkg::ALPHABET)) u_child (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .re(c_re), .raddr(c_raddr), .rdata(c_rdata)
  );

  mpbm_ram #(.WIDTH(NB), .DEPTH(MAX_NODES)) u_fail (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .re(f_re), .raddr(f_raddr), .rdata(f_rdata)
  );

  mpbm_ram #(.WIDTH(IW), .DEPTH(MAX_NODES)) u_info (
    .clk(clk), .we(i_we), .waddr(i_waddr), .wdata(i_wdata),
    .re(i_re), .raddr(i_raddr), .rdata(i_rdata_raw)
  );

  mpbm_ram #(.WIDTH(NB), .DEPTH(MAX_NODES)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .re(q_re), .raddr(q_raddr), .rdata(q_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mpbm_pkg::S_CLEAR: begin
        if (clr_r == '1) state_nxt = mpbm_pkg::S_IDLE;
      end
      mpbm_pkg::S_IDLE: begin
        if (in_fire) begin
          unique case (mpbm_pkg::action_t'(in_data.action))
            mpbm_pkg::ACT_INSERT: begin
              if (ins_err_r != mpbm_pkg::ST_ADDED || ins_depth_r >= KEY_LIMIT) begin
                state_nxt = mpbm_pkg::S_I_END;
              end else begin
                state_nxt = mpbm_pkg::S_I_CHK;
              end
            end
            mpbm_pkg::ACT_FINALIZE: state_nxt = mpbm_pkg::S_F_RRD;
            mpbm_pkg::ACT_SCAN:     state_nxt = mpbm_pkg::S_S_CRD;
            mpbm_pkg::ACT_RESTART:  state_nxt = mpbm_pkg::S_IDLE;
            default:                state_nxt = mpbm_pkg::S_IDLE;
          endcase
        end
      end
      mpbm_pkg::S_I_CHK:  state_nxt = mpbm_pkg::S_I_END;
      mpbm_pkg::S_I_END: begin
        if (!last_r) state_nxt = mpbm_pkg::S_IDLE;
        else if (ins_err_r != mpbm_pkg::ST_ADDED) state_nxt = mpbm_pkg::S_I_ERR;
        else state_nxt = mpbm_pkg::S_I_FLAG;
      end
      mpbm_pkg::S_I_FLAG, mpbm_pkg::S_I_ERR, mpbm_pkg::S_F_DONE: begin
        if (slot_free) state_nxt = mpbm_pkg::S_IDLE;
      end
      mpbm_pkg::S_F_RRD:  state_nxt = mpbm_pkg::S_F_RCHK;
      mpbm_pkg::S_F_RCHK: begin
        state_nxt = (c_r == 8'hFF) ? mpbm_pkg::S_F_DEQ : mpbm_pkg::S_F_RRD;
      end
      mpbm_pkg::S_F_DEQ: begin
        state_nxt = (head_r == tail_r) ? mpbm_pkg::S_F_DONE : mpbm_pkg::S_F_QW;
      end
      mpbm_pkg::S_F_QW:   state_nxt = mpbm_pkg::S_F_FN;
      mpbm_pkg::S_F_FN:   state_nxt = mpbm_pkg::S_F_CRD;
      mpbm_pkg::S_F_CRD:  state_nxt = mpbm_pkg::S_F_CCHK;
      mpbm_pkg::S_F_CCHK: begin
        if (!child_zero) state_nxt = mpbm_pkg::S_F_SRD;
        else if (c_r == 8'hFF) state_nxt = mpbm_pkg::S_F_DEQ;
        else state_nxt = mpbm_pkg::S_F_CRD;
      end
      mpbm_pkg::S_F_SRD:  state_nxt = mpbm_pkg::S_F_SCHK;
      mpbm_pkg::S_F_SCHK: begin
        if (child_zero && s_r != ROOT) state_nxt = mpbm_pkg::S_F_SFW;
        else if (c_r == 8'hFF) state_nxt = mpbm_pkg::S_F_DEQ;
        else state_nxt = mpbm_pkg::S_F_CRD;
      end
      mpbm_pkg::S_F_SFW:  state_nxt = mpbm_pkg::S_F_SRD;
      mpbm_pkg::S_S_CRD:  state_nxt = mpbm_pkg::S_S_CCHK;
      mpbm_pkg::S_S_CCHK: begin
        state_nxt = (child_zero && n_r != ROOT) ? mpbm_pkg::S_S_FW : mpbm_pkg::S_S_MRD;
      end
      mpbm_pkg::S_S_FW:   state_nxt = mpbm_pkg::S_S_CRD;
      mpbm_pkg::S_S_MRD: begin
        state_nxt = (n_r == ROOT || k_r == RES_LIMIT) ? mpbm_pkg::S_S_END
                                                     : mpbm_pkg::S_S_MCHK;
      end
      mpbm_pkg::S_S_MCHK: begin
        if (!(i_rdata.flag && pend_v_r && !slot_free)) state_nxt = mpbm_pkg::S_S_MRD;
      end
      mpbm_pkg::S_S_END: begin
        if (!pend_v_r || slot_free) state_nxt = mpbm_pkg::S_IDLE;
      end
      default: state_nxt = mpbm_pkg::S_IDLE;
    endcase
  end

  // datapath, memory ports and results
  always_comb begin
    clr_nxt        = clr_r;
    node_count_nxt = node_count_r;
    ins_node_nxt   = ins_node_r;
    ins_depth_nxt  = ins_depth_r;
    ins_err_nxt    = ins_err_r;
    scan_node_nxt  = scan_node_r;
    c_nxt          = c_r;
    key_nxt        = key_r;
    last_nxt       = last_r;
    n_nxt          = n_r;
    s_nxt          = s_r;
    ch_nxt         = ch_r;
    fn_nxt         = fn_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    k_nxt          = k_r;
    pend_v_nxt     = pend_v_r;
    pend_nxt       = pend_r;
    c_we = 1'b0; c_waddr = '0; c_wdata = '0; c_re = 1'b0; c_raddr = '0;
    f_we = 1'b0; f_waddr = '0; f_wdata = '0; f_re = 1'b0; f_raddr = '0;
    i_we = 1'b0; i_waddr = '0; i_wdata = '0; i_re = 1'b0; i_raddr = '0;
    q_we = 1'b0; q_waddr = '0; q_wdata = '0; q_re = 1'b0; q_raddr = '0;
    emit      = 1'b0;
    emit_data = '0;

    unique case (state_r)
      mpbm_pkg::S_CLEAR: begin
        c_we    = 1'b1;
        c_waddr = clr_r;
        clr_nxt = clr_r + 1'b1;
      end
      mpbm_pkg::S_IDLE: begin
        if (in_fire) begin
          c_nxt    = cin;
          key_nxt  = in_data.key_value;
          last_nxt = in_data.last;
          unique case (mpbm_pkg::action_t'(in_data.action))
            mpbm_pkg::ACT_INSERT: begin
              if (ins_err_r == mpbm_pkg::ST_ADDED) begin
                if (ins_depth_r >= KEY_LIMIT) begin
                  ins_err_nxt = mpbm_pkg::ST_TOOLONG;
                end else begin
                  c_re    = 1'b1;
                  c_raddr = {ins_node_r, cin};
                end
              end
            end
            mpbm_pkg::ACT_FINALIZE: begin
              c_nxt    = '0;
              head_nxt = '0;
              tail_nxt = '0;
            end
            mpbm_pkg::ACT_SCAN: begin
              n_nxt = scan_node_r;
            end
            mpbm_pkg::ACT_RESTART: begin
              scan_node_nxt = ROOT;
            end
            default: ;
          endcase
        end
      end
      mpbm_pkg::S_I_CHK: begin
        if (child_zero) begin
          if (node_count_r >= NODE_LIMIT) begin
            ins_err_nxt = mpbm_pkg::ST_FULL;
          end else begin
            // new node: link it and clear its fail link and flag
            c_we    = 1'b1;
            c_waddr = {ins_node_r, c_r};
            c_wdata = node_count_r[NB-1:0];
            f_we    = 1'b1;
            f_waddr = node_count_r[NB-1:0];
            f_wdata = ROOT;
            i_we    = 1'b1;
            i_waddr = node_count_r[NB-1:0];
            i_wdata = '0;
            ins_node_nxt   = node_count_r[NB-1:0];
            ins_depth_nxt  = ins_depth_r + 1'b1;
            node_count_nxt = node_count_r + 1'b1;
          end
        end else begin
          ins_node_nxt  = c_rdata;
          ins_depth_nxt = ins_depth_r + 1'b1;
        end
      end
      mpbm_pkg::S_I_END: begin
        if (last_r && ins_err_r == mpbm_pkg::ST_ADDED) begin
          i_re    = 1'b1;
          i_raddr = ins_node_r;
        end
      end
      mpbm_pkg::S_I_FLAG: begin
        if (slot_free) begin
          emit                   = 1'b1;
          emit_data.kind         = mpbm_pkg::KIND_INSERT;
          emit_data.final_report = 1'b1;
          if (i_rdata.flag) begin
            emit_data.status = mpbm_pkg::ST_DUP;
          end else begin
            emit_data.status = mpbm_pkg::ST_ADDED;
            i_we         = 1'b1;
            i_waddr      = ins_node_r;
            i_wdata.flag = 1'b1;
            i_wdata.key  = key_r;
          end
          ins_node_nxt  = ROOT;
          ins_depth_nxt = '0;
          ins_err_nxt   = mpbm_pkg::ST_ADDED;
        end
      end
      mpbm_pkg::S_I_ERR: begin
        if (slot_free) begin
          emit                   = 1'b1;
          emit_data.kind         = mpbm_pkg::KIND_INSERT;
          emit_data.status       = ins_err_r;
          emit_data.final_report = 1'b1;
          ins_node_nxt  = ROOT;
          ins_depth_nxt = '0;
          ins_err_nxt   = mpbm_pkg::ST_ADDED;
        end
      end
      mpbm_pkg::S_F_RRD: begin
        c_re    = 1'b1;
        c_raddr = {ROOT, c_r};
      end
      mpbm_pkg::S_F_RCHK: begin
        // root children keep fail link root, only queue them
        if (!child_zero) begin
          q_we     = 1'b1;
          q_waddr  = tail_r;
          q_wdata  = c_rdata;
          tail_nxt = tail_r + 1'b1;
        end
        c_nxt = c_r + 1'b1;
      end
      mpbm_pkg::S_F_DEQ: begin
        if (head_r != tail_r) begin
          q_re     = 1'b1;
          q_raddr  = head_r;
          head_nxt = head_r + 1'b1;
        end
      end
      mpbm_pkg::S_F_QW: begin
        n_nxt   = q_rdata;
        f_re    = 1'b1;
        f_raddr = q_rdata;
      end
      mpbm_pkg::S_F_FN: begin
        fn_nxt = f_rdata;
        c_nxt  = '0;
      end
      mpbm_pkg::S_F_CRD: begin
        c_re    = 1'b1;
        c_raddr = {n_r, c_r};
      end
      mpbm_pkg::S_F_CCHK: begin
        if (!child_zero) begin
          q_we     = 1'b1;
          q_waddr  = tail_r;
          q_wdata  = c_rdata;
          tail_nxt = tail_r + 1'b1;
          ch_nxt   = c_rdata;
          s_nxt    = fn_r;
        end else begin
          c_nxt = c_r + 1'b1;
        end
      end
      mpbm_pkg::S_F_SRD: begin
        c_re    = 1'b1;
        c_raddr = {s_r, c_r};
      end
      mpbm_pkg::S_F_SCHK: begin
        if (child_zero && s_r != ROOT) begin
          f_re    = 1'b1;
          f_raddr = s_r;
        end else begin
          f_we    = 1'b1;
          f_waddr = ch_r;
          f_wdata = c_rdata;
          c_nxt   = c_r + 1'b1;
        end
      end
      mpbm_pkg::S_F_SFW: begin
        s_nxt = f_rdata;
      end
      mpbm_pkg::S_F_DONE: begin
        if (slot_free) begin
          emit                   = 1'b1;
          emit_data.kind         = mpbm_pkg::KIND_FINAL;
          emit_data.final_report = 1'b1;
        end
      end
      mpbm_pkg::S_S_CRD: begin
        c_re    = 1'b1;
        c_raddr = {n_r, c_r};
      end
      mpbm_pkg::S_S_CCHK: begin
        if (child_zero && n_r != ROOT) begin
          f_re    = 1'b1;
          f_raddr = n_r;
        end else begin
          if (!child_zero) begin
            n_nxt         = c_rdata;
            scan_node_nxt = c_rdata;
          end else begin
            scan_node_nxt = n_r;
          end
          k_nxt      = '0;
          pend_v_nxt = 1'b0;
        end
      end
      mpbm_pkg::S_S_FW: begin
        n_nxt = f_rdata;
      end
      mpbm_pkg::S_S_MRD: begin
        if (n_r != ROOT && k_r != RES_LIMIT) begin
          i_re    = 1'b1;
          i_raddr = n_r;
          f_re    = 1'b1;
          f_raddr = n_r;
        end
      end
      mpbm_pkg::S_S_MCHK: begin
        // one report is held back so the last can carry the final flag
        if (i_rdata.flag) begin
          if (!pend_v_r || slot_free) begin
            if (pend_v_r) begin
              emit                  = 1'b1;
              emit_data.kind        = mpbm_pkg::KIND_MATCH;
              emit_data.match_value = pend_r;
            end
            pend_v_nxt = 1'b1;
            pend_nxt   = i_rdata.key;
            k_nxt      = k_r + 1'b1;
            n_nxt      = f_rdata;
          end
        end else begin
          n_nxt = f_rdata;
        end
      end
      mpbm_pkg::S_S_END: begin
        if (pend_v_r && slot_free) begin
          emit                   = 1'b1;
          emit_data.kind         = mpbm_pkg::KIND_MATCH;
          emit_data.match_value  = pend_r;
          emit_data.final_report = 1'b1;
          pend_v_nxt             = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_nxt       = emit ? emit_data : out_r;
    out_valid_nxt = emit ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= mpbm_pkg::S_CLEAR;
      case_fold_r  <= 1'b0;
      clr_r        <= '0;
      node_count_r <= (NB + 1)'(1);
      ins_node_r   <= ROOT;
      ins_depth_r  <= '0;
      ins_err_r    <= '0;
      scan_node_r  <= ROOT;
      out_valid_r  <= 1'b0;
      pend_v_r     <= 1'b0;
      k_r          <= '0;
      head_r       <= '0;
      tail_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      if (cfg_we) begin
        case_fold_r <= cfg_wdata;
      end
      clr_r        <= clr_nxt;
      node_count_r <= node_count_nxt;
      ins_node_r   <= ins_node_nxt;
      ins_depth_r  <= ins_depth_nxt;
      ins_err_r    <= ins_err_nxt;
      scan_node_r  <= scan_node_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_v_r     <= pend_v_nxt;
      k_r          <= k_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_r    <= c_nxt;
    key_r  <= key_nxt;
    last_r <= last_nxt;
    n_r    <= n_nxt;
    s_r    <= s_nxt;
    ch_r   <= ch_nxt;
    fn_r   <= fn_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

endmodule
